// ===== hdl/dvog_pkg.sv =====
package dvog_pkg;

  // One packet byte on the input channel
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // One verdict on the result channel
  typedef struct packed {
    logic        pass;
    logic [2:0]  reason;
    logic [15:0] subopt_length;
  } out_word_t;

  // Configuration register file as seen by the parser
  typedef struct packed {
    logic               gate_enable;
    logic               vendor_needed;
    logic signed [16:0] required_subopt;
    logic [31:0]        enterprise_number;
    logic [15:0]        vendor_option_code;
  } cfg_regs_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_VENDOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_SUBOPT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTERPRISE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_CODE   = 3'd4;

  localparam logic [15:0] VENDOR_CODE_RST  = 16'd17;
  localparam logic [7:0]  MSG_ADVERTISE    = 8'd2;
  localparam logic [2:0]  HDR_LEN          = 3'd4;

  typedef enum logic [2:0] {
    RSN_DISABLED   = 3'd0,
    RSN_NO_VENDOR  = 3'd1,
    RSN_ALL_PASSED = 3'd2,
    RSN_SHORT      = 3'd3,
    RSN_NOT_ADV    = 3'd4,
    RSN_NO_VOPT    = 3'd5,
    RSN_NO_SUBOPT  = 3'd6
  } reason_t;

  typedef enum logic [2:0] {
    PH_HDR      = 3'd0,
    PH_OPTHDR   = 3'd1,
    PH_SKIP     = 3'd2,
    PH_VENT     = 3'd3,
    PH_VSUBHDR  = 3'd4,
    PH_VSUBSKIP = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

endpackage

// ===== hdl/dvog_parser.sv =====
module dvog_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  dvog_pkg::cfg_regs_t cfg_i,
  output dvog_pkg::out_word_t verdict_o
);
  import dvog_pkg::*;

  phase_t      phase_r,     phase_nxt;
  logic [2:0]  hdr_cnt_r,   hdr_cnt_nxt;   // saturates at header length
  logic        msg_adv_r,   msg_adv_nxt;
  logic [31:0] shift_r,     shift_nxt;
  logic [1:0]  fcnt_r,      fcnt_nxt;
  logic [15:0] opt_left_r,  opt_left_nxt;
  logic [15:0] vend_left_r, vend_left_nxt;
  logic [15:0] sub_left_r,  sub_left_nxt;
  logic        vfound_r,    vfound_nxt;
  logic        sfound_r,    sfound_nxt;
  logic        stopped_r,   stopped_nxt;
  logic [15:0] flen_r,      flen_nxt;

  logic [31:0] sh;
  logic        fdone;
  logic [15:0] ol, vl, sl;
  logic        need_sub;

  assign sh       = {shift_r[23:0], byte_i};
  assign fdone    = (fcnt_r == 2'd3);
  assign need_sub = !cfg_i.required_subopt[16];
  assign ol       = opt_left_r  - 16'(opt_left_r  != 16'd0);
  assign vl       = vend_left_r - 16'(vend_left_r != 16'd0);
  assign sl       = sub_left_r  - 16'(sub_left_r  != 16'd0);

  always_comb begin
    phase_nxt     = phase_r;
    msg_adv_nxt   = msg_adv_r;
    shift_nxt     = shift_r;
    fcnt_nxt      = fcnt_r;
    opt_left_nxt  = opt_left_r;
    vend_left_nxt = vend_left_r;
    sub_left_nxt  = sub_left_r;
    vfound_nxt    = vfound_r;
    sfound_nxt    = sfound_r;
    stopped_nxt   = stopped_r;
    flen_nxt      = flen_r;
    hdr_cnt_nxt   = (hdr_cnt_r == HDR_LEN) ? hdr_cnt_r : hdr_cnt_r + 3'd1;

    unique case (phase_r)
      PH_HDR: begin
        if (hdr_cnt_r == 3'd0) msg_adv_nxt = (byte_i == MSG_ADVERTISE);
        if (hdr_cnt_r >= 3'd3) phase_nxt = PH_OPTHDR;
      end
      PH_OPTHDR: begin
        shift_nxt = sh;
        fcnt_nxt  = fcnt_r + 2'd1;
        if (fdone) begin
          if (sh[31:16] == cfg_i.vendor_option_code) begin
            vend_left_nxt = sh[15:0];
            if (sh[15:0] == 16'd0) begin
              vfound_nxt = 1'b1;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_VENT;
            end
          end else if (sh[15:0] != 16'd0) begin
            opt_left_nxt = sh[15:0];
            phase_nxt    = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        opt_left_nxt = ol;
        if (ol == 16'd0) phase_nxt = PH_OPTHDR;
      end
      PH_VENT, PH_VSUBHDR, PH_VSUBSKIP: begin
        vend_left_nxt = vl;
        if (phase_r == PH_VENT) begin
          shift_nxt = sh;
          fcnt_nxt  = fcnt_r + 2'd1;
          if (fdone) begin
            if (sh != cfg_i.enterprise_number) stopped_nxt = 1'b1;
            phase_nxt = PH_VSUBHDR;
          end
        end else if (phase_r == PH_VSUBHDR) begin
          if (!stopped_r) begin
            shift_nxt = sh;
            fcnt_nxt  = fcnt_r + 2'd1;
            if (fdone) begin
              if (sh[15:0] > vl) begin
                stopped_nxt = 1'b1;
              end else if (need_sub && sh[31:16] == cfg_i.required_subopt[15:0]) begin
                sfound_nxt  = 1'b1;
                flen_nxt    = sh[15:0];
                stopped_nxt = 1'b1;
              end else if (sh[15:0] != 16'd0) begin
                sub_left_nxt = sh[15:0];
                phase_nxt    = PH_VSUBSKIP;
              end
            end
          end
        end else begin
          sub_left_nxt = sl;
          if (sl == 16'd0) phase_nxt = PH_VSUBHDR;
        end
        if (vl == 16'd0) begin
          vfound_nxt = 1'b1;
          phase_nxt  = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // Verdict from the state as it stands after this byte
  always_comb begin
    verdict_o = '0;
    if (!cfg_i.gate_enable) begin
      verdict_o.pass   = 1'b1;
      verdict_o.reason = RSN_DISABLED;
    end else if (hdr_cnt_nxt < HDR_LEN) begin
      verdict_o.reason = RSN_SHORT;
    end else if (!msg_adv_nxt) begin
      verdict_o.reason = RSN_NOT_ADV;
    end else if (!cfg_i.vendor_needed) begin
      verdict_o.pass   = 1'b1;
      verdict_o.reason = RSN_NO_VENDOR;
    end else if (!vfound_nxt) begin
      verdict_o.reason = RSN_NO_VOPT;
    end else if (!need_sub) begin
      verdict_o.pass   = 1'b1;
      verdict_o.reason = RSN_ALL_PASSED;
    end else if (!sfound_nxt) begin
      verdict_o.reason = RSN_NO_SUBOPT;
    end else begin
      verdict_o.pass          = 1'b1;
      verdict_o.reason        = RSN_ALL_PASSED;
      verdict_o.subopt_length = flen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_i && last_i)) begin
      phase_r     <= PH_HDR;
      hdr_cnt_r   <= '0;
      msg_adv_r   <= 1'b0;
      shift_r     <= '0;
      fcnt_r      <= '0;
      opt_left_r  <= '0;
      vend_left_r <= '0;
      sub_left_r  <= '0;
      vfound_r    <= 1'b0;
      sfound_r    <= 1'b0;
      stopped_r   <= 1'b0;
      flen_r      <= '0;
    end else if (step_i) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      msg_adv_r   <= msg_adv_nxt;
      shift_r     <= shift_nxt;
      fcnt_r      <= fcnt_nxt;
      opt_left_r  <= opt_left_nxt;
      vend_left_r <= vend_left_nxt;
      sub_left_r  <= sub_left_nxt;
      vfound_r    <= vfound_nxt;
      sfound_r    <= sfound_nxt;
      stopped_r   <= stopped_nxt;
      flen_r      <= flen_nxt;
    end
  end

  // field byte counter is zero in the header phase and in both skip phases
  a_fcnt_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP || phase_r == PH_VSUBSKIP || phase_r == PH_HDR) |-> fcnt_r == 2'd0)
    else $error("field counter not aligned");
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    sfound_r |-> (stopped_r && vend_left_r <= vend_left_r + 16'd0) && phase_r != PH_VSUBSKIP)
    else $error("sub-option found but search still running");
  a_vfound_phase: assert property (@(posedge clk) disable iff (!rst_n)
    vfound_r |-> phase_r == PH_DONE)
    else $error("vendor option found outside done phase");

endmodule

// ===== hdl/dvog_out_reg.sv =====
module dvog_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  dvog_pkg::out_word_t word_i,
  output logic                free_o,
  output logic                out_valid,
  input  logic                out_ready,
  output dvog_pkg::out_word_t out_data
);
  import dvog_pkg::*;

  logic      valid_r, valid_nxt;
  out_word_t data_r;

  assign free_o    = !valid_r || out_ready;
  assign valid_nxt = load_i ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) data_r <= word_i;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> free_o)
    else $error("verdict loaded over an untaken one");

endmodule

// ===== hdl/dhcpv6_vendor_option_gate.sv =====
// Channel | Ports                          | Word
// --------+--------------------------------+--------------------------------------
// input   | in_valid  in_ready  in_data    | data_byte, last_byte
// result  | out_valid out_ready out_data   | pass, reason, subopt_length
// config  | cfg_valid cfg_ready cfg_index  | cfg_data (index 0..4, always ready)
//
// One byte word per cycle sustained, unless a last byte waits on a held verdict;
// a verdict leaves after its last byte is accepted, through the input register, then the verdict register.
// Per-byte work is one parser state update between those two registers.
// rst_n is synchronous, active low; it clears the parser and both valids.
// A held verdict stalls only a last byte in the input register; other bytes
// keep flowing, and in_ready follows out_ready combinationally.
module dhcpv6_vendor_option_gate (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dvog_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dvog_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dvog_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dvog_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dvog_pkg::*;

  // input register
  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_data_r;
  logic      in_acc;
  logic      consume;
  logic      out_free;

  // configuration registers
  cfg_regs_t cfg_r, cfg_nxt;

  out_word_t verdict;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GATE_ENABLE: cfg_nxt.gate_enable        = cfg_data[0];
        CFG_REQ_VENDOR:  cfg_nxt.vendor_needed      = cfg_data[0];
        CFG_REQ_SUBOPT:  cfg_nxt.required_subopt    = signed'(cfg_data[16:0]);
        CFG_ENTERPRISE:  cfg_nxt.enterprise_number  = cfg_data;
        CFG_VENDOR_CODE: cfg_nxt.vendor_option_code = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_enable        <= 1'b0;
      cfg_r.vendor_needed      <= 1'b0;
      cfg_r.required_subopt    <= -17'sd1;
      cfg_r.enterprise_number  <= '0;
      cfg_r.vendor_option_code <= VENDOR_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a last byte moves on only when the verdict register can take its verdict
  assign consume      = s1_valid_r && (!s1_data_r.last_byte || out_free);
  assign in_ready     = !s1_valid_r || consume;
  assign in_acc       = in_valid && in_ready;
  assign s1_valid_nxt = in_acc ? 1'b1 : (consume ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_data_r <= in_data;
  end

  dvog_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (consume),
    .byte_i    (s1_data_r.data_byte),
    .last_i    (s1_data_r.last_byte),
    .cfg_i     (cfg_r),
    .verdict_o (verdict)
  );

  dvog_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (consume && s1_data_r.last_byte),
    .word_i    (verdict),
    .free_o    (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // passing verdicts carry only passing reasons, and the other way round
  a_pass_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pass == (out_data.reason == RSN_DISABLED ||
                                     out_data.reason == RSN_NO_VENDOR ||
                                     out_data.reason == RSN_ALL_PASSED)))
    else $error("pass flag disagrees with reason");
  a_len_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.reason != RSN_ALL_PASSED) |-> out_data.subopt_length == 16'd0)
    else $error("sub-option length without full pass");
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(consume && s1_data_r.last_byte))
    else $error("verdict appeared without a last byte");

endmodule
